[sv/decaying_echo_fir_reverb_assert.svh]
// Assertion macros used by the reverb RTL
`ifndef DECAYING_ECHO_FIR_REVERB_ASSERT_SVH
`define DECAYING_ECHO_FIR_REVERB_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define DEFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define DEFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/defr_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants and register codes of the decaying echo FIR reverb
package defr_pkg;

    localparam int DATA_W     = 16;
    localparam int D_W        = 9;
    localparam int GAIN_W     = 16;
    localparam int FRAC_W     = 14;
    localparam int ACC_W      = 34;
    localparam int PROD_W     = ACC_W + GAIN_W;
    localparam int NUM_W      = PROD_W - FRAC_W;
    localparam int DIV_CNT_W  = 6;
    localparam int SUM_W      = NUM_W + 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [D_W-1:0]    DELAY_RST = 9'd0;
    localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd8192;

    localparam logic [DATA_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_TAPS = 1'b0,
        CFG_GAIN_Q14   = 1'b1
    } t_cfg_reg;

endpackage

[sv/defr_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module defr_div
    import defr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [D_W-1:0]   i_divisor,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_quo;
    logic [D_W-1:0]       r_rem;
    logic [D_W-1:0]       r_div;

    logic [D_W:0]         w_rem_sh;
    logic [D_W:0]         w_diff;
    logic                 w_ge;

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});
    assign w_diff   = w_rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_rem_sh[D_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/decaying_echo_fir_reverb.sv]
`timescale 1ns / 1ps
// Decaying echo FIR reverb: per-channel triangular-weight FIR over a history memory
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready | tdata sample_in, tuser channel
//  m_axis   | out       | m_axis_tvalid / m_axis_tready | tdata sample_out, tuser channel_out
//  cfg      | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  An item makes one history read and one multiply-accumulate per tap over D taps (D =
//  effective delay_taps), then a 36-step serial divide; pass-through skips both.
//  One item is in flight at a time; the output register frees the input while a result waits.
//  Reset clears pointers and fill counts; taps older than reset read as zero, no clearing pass.
//  Output stall holds the finished result and the next item's final step until taken.
`include "decaying_echo_fir_reverb_assert.svh"

module decaying_echo_fir_reverb
    import defr_pkg::*;
#(
    parameter int MAX_TAPS = 256,
    parameter int CHANNELS = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // [15:0] sample_in
    input  logic                  s_axis_tuser,   // [0] channel
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,   // [15:0] sample_out
    output logic                  m_axis_tuser,   // [0] channel_out
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int TAP_W     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int FILL_W    = $clog2(MAX_TAPS + 1);
    localparam int CI_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MEM_DEPTH = CHANNELS * MAX_TAPS;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CMP_W     = (D_W > FILL_W) ? D_W : FILL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_ABS,
        S_MUL_LO,
        S_MUL_HI,
        S_DIV,
        S_FIN
    } t_state;

    t_state               r_state;

    logic [D_W-1:0]       r_delay;
    logic [GAIN_W-1:0]    r_gain;

    logic [TAP_W-1:0]     r_wp   [CHANNELS];
    logic [FILL_W-1:0]    r_fill [CHANNELS];

    logic [DATA_W-1:0]    r_mem  [MEM_DEPTH];
    logic [DATA_W-1:0]    r_rdata;

    logic [DATA_W-1:0]    r_x;
    logic                 r_ch;
    logic [CI_W-1:0]      r_ci;
    logic [TAP_W-1:0]     r_tap;
    logic [D_W-1:0]       r_k;
    logic [D_W-1:0]       r_d;
    logic [FILL_W-1:0]    r_fill_cur;

    logic                 r_mac_vld;
    logic [D_W-1:0]       r_mac_w;
    logic                 r_mac_zero;
    logic [ACC_W-1:0]     r_acc;

    logic                 r_neg;
    logic [ACC_W-1:0]     r_mag;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_div_start;
    logic [NUM_W-1:0]     r_quot;

    logic                 r_m_tvalid;
    logic [DATA_W-1:0]    r_m_tdata;
    logic                 r_m_tuser;

    logic                 w_accept;
    logic                 w_ch_ok;
    logic [CI_W-1:0]      w_ci;
    logic [D_W-1:0]       w_d_eff;
    logic                 w_bypass;
    logic [TAP_W-1:0]     w_wp;
    logic [TAP_W-1:0]     w_wp_next;
    logic [FILL_W-1:0]    w_fill_cur;
    logic [FILL_W-1:0]    w_fill_new;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [AW-1:0]        w_raddr;
    logic [DATA_W-1:0]    w_tap;
    logic signed [DATA_W+D_W:0] w_term;
    logic [31:0]          w_lo_prod;
    logic [ACC_W-1:0]     w_hi_prod;
    logic                 w_div_done;
    logic [NUM_W-1:0]     w_div_quot;
    logic [SUM_W-1:0]     w_x_ext;
    logic [SUM_W-1:0]     w_q_ext;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_fits;
    logic [DATA_W-1:0]    w_sat;
    logic                 w_out_free;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_DELAY_TAPS: r_delay <= i_cfg_data[D_W-1:0];
                CFG_GAIN_Q14:   r_gain  <= i_cfg_data[GAIN_W-1:0];
                default:        r_delay <= r_delay;
            endcase
        end
    end

    // request decode
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_ch_ok       = (int'(s_axis_tuser) < CHANNELS);
    assign w_ci          = CI_W'(s_axis_tuser);
    assign w_d_eff       = (CMP_W'(r_delay) > CMP_W'(MAX_TAPS)) ? D_W'(MAX_TAPS) : r_delay;
    assign w_bypass      = !w_ch_ok || (w_d_eff == '0);
    assign w_wp          = r_wp[w_ci];
    assign w_wp_next     = (w_wp == TAP_W'(MAX_TAPS - 1)) ? '0 : w_wp + 1'b1;
    assign w_fill_cur    = r_fill[w_ci];
    assign w_fill_new    = (w_fill_cur == FILL_W'(MAX_TAPS)) ? w_fill_cur : w_fill_cur + 1'b1;

    // history memory
    assign w_we    = w_accept && w_ch_ok;
    assign w_waddr = AW'(w_ci) * AW'(MAX_TAPS) + AW'(w_wp);
    assign w_raddr = AW'(r_ci) * AW'(MAX_TAPS) + AW'(r_tap);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= s_axis_tdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // arithmetic
    assign w_tap     = r_mac_zero ? '0 : r_rdata;
    assign w_term    = $signed(w_tap) * $signed({1'b0, r_mac_w});
    assign w_lo_prod = r_mag[15:0] * r_gain;
    assign w_hi_prod = r_mag[ACC_W-1:16] * r_gain;

    assign w_x_ext = {{(SUM_W-DATA_W){r_x[DATA_W-1]}}, r_x};
    assign w_q_ext = {2'b00, r_quot};
    assign w_sum   = r_neg ? (w_x_ext - w_q_ext) : (w_x_ext + w_q_ext);
    assign w_fits  = (&w_sum[SUM_W-1:DATA_W-1]) || !(|w_sum[SUM_W-1:DATA_W-1]);
    assign w_sat   = w_fits ? w_sum[DATA_W-1:0] : (w_sum[SUM_W-1] ? SAT_NEG : SAT_POS);

    assign w_out_free = !r_m_tvalid || m_axis_tready;

    defr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_prod[PROD_W-1:FRAC_W]),
        .i_divisor  (r_d),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mac_vld   <= 1'b0;
            r_div_start <= 1'b0;
            r_m_tvalid  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_wp[c]   <= '0;
                r_fill[c] <= '0;
            end
        end else begin
            r_mac_vld   <= (r_state == S_READ);
            r_div_start <= (r_state == S_MUL_HI);
            if (m_axis_tready && (r_state != S_FIN)) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_ch_ok) begin
                            r_wp[w_ci]   <= w_wp_next;
                            r_fill[w_ci] <= w_fill_new;
                        end
                        r_state <= w_bypass ? S_FIN : S_READ;
                    end
                end
                S_READ: begin
                    if (r_k == r_d - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN:  r_state <= S_ABS;
                S_ABS:    r_state <= S_MUL_LO;
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_m_tvalid <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_mac_vld) begin
            r_acc <= r_acc + {{(ACC_W-DATA_W-D_W-1){w_term[DATA_W+D_W]}}, w_term};
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_x        <= s_axis_tdata;
                    r_ch       <= s_axis_tuser;
                    r_ci       <= w_ci;
                    r_tap      <= w_wp;
                    r_k        <= '0;
                    r_d        <= w_d_eff;
                    r_fill_cur <= w_fill_new;
                    r_acc      <= '0;
                    r_neg      <= 1'b0;
                    r_quot     <= '0;
                end
            end
            S_READ: begin
                r_mac_w    <= r_d - r_k;
                r_mac_zero <= (CMP_W'(r_k) >= CMP_W'(r_fill_cur));
                r_k        <= r_k + 1'b1;
                r_tap      <= (r_tap == '0) ? TAP_W'(MAX_TAPS - 1) : r_tap - 1'b1;
            end
            S_ABS: begin
                r_neg <= r_acc[ACC_W-1];
                r_mag <= r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
            end
            S_MUL_LO: r_prod <= {{(PROD_W-32){1'b0}}, w_lo_prod};
            S_MUL_HI: r_prod <= r_prod + {w_hi_prod, 16'h0000};
            S_DIV: begin
                if (w_div_done) begin
                    r_quot <= w_div_quot;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_m_tdata <= w_sat;
                    r_m_tuser <= r_ch;
                end
            end
            default: r_k <= r_k;
        endcase
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    `DEFR_ASSERT_NOW(a_mac_in_sweep, r_mac_vld, (r_state == S_READ) || (r_state == S_DRAIN), "tap accumulate outside the tap sweep")
    `DEFR_ASSERT_NOW(a_div_done_in_div, w_div_done, r_state == S_DIV, "divider finished outside the divide step")
    `DEFR_ASSERT_NEXT(a_bypass_to_fin, w_accept && w_bypass, r_state == S_FIN, "pass-through request did not go to the final step")

endmodule

[test/tb_decaying_echo_fir_reverb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the decaying echo FIR reverb with a triangular-tap predictor
module tb_decaying_echo_fir_reverb;
    import defr_pkg::*;

    localparam int MAX_TAPS    = 256;
    localparam int CHANNELS    = 2;
    localparam int DIR_N       = 32;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 79;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        t_cfg_reg          reg_sel;
        logic              chn;
        logic [DATA_W-1:0] data;
        logic              known;
        logic [DATA_W-1:0] want;
    } t_dir_row;

    typedef struct packed {
        logic [DATA_W-1:0] smp;
        logic              chn;
    } t_reverb_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_DELAY_TAPS;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic signed [DATA_W-1:0] hist_mem [0:CHANNELS-1][0:MAX_TAPS-1];
    logic [7:0]               wr_ptr [0:CHANNELS-1];
    logic [D_W-1:0]           taps_cfg = DELAY_RST;
    logic [GAIN_W-1:0]        gain_cfg = GAIN_RST;

    t_reverb_out reverb_out_q [$];
    int          mismatch_cnt = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;

    t_dir_row dir_tab [0:DIR_N-1] = '{
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h7FFF, 1'b1, 16'h7FFF},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'h8000, 1'b1, 16'h8000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h0000, 1'b1, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF},
        '{ROW_CFG,    CFG_GAIN_Q14,   1'b0, 16'h4000, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_DELAY_TAPS, 1'b0, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h7FFF, 1'b1, SAT_POS},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'h8000, 1'b1, SAT_NEG},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h1234, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_GAIN_Q14,   1'b0, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'h8000, 1'b1, 16'h8000},
        '{ROW_CFG,    CFG_DELAY_TAPS, 1'b0, 16'h0100, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_GAIN_Q14,   1'b0, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h7FFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'h8000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'h5555, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'hAAAA, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_DELAY_TAPS, 1'b0, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'hFFFE, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_DELAY_TAPS, 1'b0, 16'h012C, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_GAIN_Q14,   1'b0, 16'h0001, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h4000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'hC000, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_DELAY_TAPS, 1'b0, 16'h0002, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_GAIN_Q14,   1'b0, 16'h2000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h0100, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'hFF00, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b0, 16'h8000, 1'b0, 16'h0000},
        '{ROW_CFG,    CFG_DELAY_TAPS, 1'b0, 16'h0000, 1'b0, 16'h0000},
        '{ROW_SAMPLE, CFG_DELAY_TAPS, 1'b1, 16'h1357, 1'b1, 16'h1357}
    };

    decaying_echo_fir_reverb #(
        .MAX_TAPS(MAX_TAPS),
        .CHANNELS(CHANNELS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [DATA_W-1:0] reverb_sample(input logic [DATA_W-1:0] smp,
                                                        input logic chn);
        int         d;
        int         k;
        logic [7:0] wp;
        logic [7:0] idx;
        longint     acc;
        longint     y;
        d = (int'(taps_cfg) > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
        wp = wr_ptr[chn];
        hist_mem[chn][wp] = smp;
        acc = 0;
        for (k = 0; k < d; k++) begin
            idx = wp - 8'(k);
            acc += longint'(hist_mem[chn][idx]) * longint'(d - k);
        end
        y = longint'($signed(smp));
        if (d > 0) begin
            y += (acc * longint'(gain_cfg)) / (longint'(d) * 16384);
        end
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        wr_ptr[chn] = wp + 8'd1;
        return y[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] rand_sample();
        case ($urandom_range(7, 0))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (mismatch_cnt < 10) begin
            $display("mismatch at %0t: %s expected %h got %h", $time, what, want, got);
        end
        mismatch_cnt++;
    endtask

    // hold the request until taken, then record what it must produce
    task automatic push_sample(input logic [DATA_W-1:0] smp, input logic chn,
                               input logic known, input logic [DATA_W-1:0] want);
        t_reverb_out item;
        logic [DATA_W-1:0] pred;
        while ($urandom_range(99, 0) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = smp;
        s_axis_tuser = chn;
        do @(posedge i_clk); while (!s_axis_tready);
        pred = reverb_sample(smp, chn);
        item.smp = known ? want : pred;
        item.chn = chn;
        reverb_out_q.insert(reverb_out_q.size(), item);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (reverb_out_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg sel, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (sel)
            CFG_DELAY_TAPS: taps_cfg = data[D_W-1:0];
            CFG_GAIN_Q14:   gain_cfg = data[GAIN_W-1:0];
            default:        gain_cfg = gain_cfg;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end

    always @(posedge i_clk) begin : check_out
        t_reverb_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (reverb_out_q.size() == 0) begin
                flag_mismatch("unexpected sample", '0, m_axis_tdata);
            end else begin
                want = reverb_out_q.pop_front();
                if (m_axis_tdata !== want.smp) begin
                    flag_mismatch("sample_out", want.smp, m_axis_tdata);
                end
                if (m_axis_tuser !== want.chn) begin
                    flag_mismatch("channel_out", 16'(want.chn), 16'(m_axis_tuser));
                end
            end
        end
    end

    initial begin
        int       r;
        int       p;
        int       n;
        int       dly;
        t_dir_row row;
        for (int c = 0; c < CHANNELS; c++) begin
            wr_ptr[c] = 8'd0;
            for (int t = 0; t < MAX_TAPS; t++) hist_mem[c][t] = '0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (r = 0; r < DIR_N; r++) begin
            row = dir_tab[r];
            if (row.kind == ROW_CFG) begin
                drain_results();
                write_reg(row.reg_sel, row.data);
            end else begin
                push_sample(row.data, row.chn, row.known, row.want);
            end
        end

        for (p = 0; p < RAND_PHASES; p++) begin
            drain_results();
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
                default: begin src_idle_pct = 18; snk_stall_pct = 18; end
            endcase
            if (p == 3) dly = MAX_TAPS;
            else if (p == 6) dly = $urandom_range(511, MAX_TAPS + 1);
            else dly = $urandom_range(24, 0);
            write_reg(CFG_DELAY_TAPS, {7'($urandom), 9'(dly)});
            if (p == 1) write_reg(CFG_GAIN_Q14, 16'hFFFF);
            else if (p == 2) write_reg(CFG_GAIN_Q14, 16'h0000);
            else write_reg(CFG_GAIN_Q14, 16'($urandom));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                push_sample(rand_sample(), 1'($urandom), 1'b0, '0);
            end
        end

        drain_results();
        repeat (320) @(negedge i_clk);
        if (mismatch_cnt == 0 && reverb_out_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
